/* sv/swm_pkg.sv */
package swm_pkg;

    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // window_size register
    localparam int             CFG_WIDTH = 7;
    localparam logic [6:0]     CFG_RESET = 7'd3;

    // leaves per first-level node of the registered median select tree
    localparam int SEL_GROUP = 8;

    // per-cell flags seen by the neighbors
    typedef struct packed {
        logic le;   // entry holds a sample not above the new one
        logic lt;   // entry lies below the slot that leaves the window
    } t_cell_flags;

    // per-cell control from the top level
    typedef struct packed {
        logic valid;    // cell holds a sample of the current window
        logic keep;     // cell may lie below the departing slot
        logic use_old;  // window full: a sample leaves on this beat
    } t_cell_ctl;

endpackage

/* sv/sliding_window_median_unit.sv */
// Sliding-window lower median. One sample is taken per clock while the output
// is not stalled; the median of the window passes the pending, group and output
// registers after the sample that completes it. After reset or a write of
// window_size the first window_size - 1 samples only fill the window and give no
// result. The window is held sorted in a row of MAX_WINDOW compare-and-shift
// cells that take out the departing sample and place the new one together; the
// departing value comes from a ring memory whose read address runs ahead of the
// writes, and the median is picked out of the row by a two-level registered
// select. A window_size of 0 acts as 1, one above MAX_WINDOW acts as MAX_WINDOW.
// There is no clearing pass after reset.
module sliding_window_median_unit #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_sample_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]   o_median_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [swm_pkg::CFG_WIDTH-1:0]    i_window_size
);

    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int GROUP  = swm_pkg::SEL_GROUP;
    localparam int NGROUP = (MAX_WINDOW + GROUP - 1) / GROUP;
    localparam int PAD    = NGROUP * GROUP;

    logic [swm_pkg::CFG_WIDTH-1:0] r_win;
    logic [CNT_W-1:0]              r_fill;
    logic [CNT_W-1:0]              n_fill;
    logic [IDX_W-1:0]              r_ptr;
    logic [IDX_W-1:0]              n_ptr;
    logic [CNT_W-1:0]              w_eff;
    logic [IDX_W-1:0]              mid;
    logic                          filling;
    logic                          advance;
    logic                          accept;
    logic                          produce;
    logic                          cfg_wr;
    logic [IDX_W-1:0]              wr_addr;
    logic [SAMPLE_WIDTH-1:0]       old_raw;

    logic                          r_pend;
    logic                          r_grp_v;
    logic                          r_out_v;
    logic [SAMPLE_WIDTH-1:0]       r_grp [NGROUP];
    logic [SAMPLE_WIDTH-1:0]       n_grp [NGROUP];
    logic [SAMPLE_WIDTH-1:0]       r_out;
    logic [SAMPLE_WIDTH-1:0]       n_out;

    logic signed [SAMPLE_WIDTH-1:0] cell_val [MAX_WINDOW];
    swm_pkg::t_cell_flags           cell_flg [MAX_WINDOW];
    swm_pkg::t_cell_ctl             cell_ctl [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0]        sel_val  [PAD];

    always_comb begin
        if (r_win == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_win) > 32'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(r_win);
        end
    end

    assign mid         = IDX_W'((w_eff - CNT_W'(1)) >> 1);
    assign filling     = (r_fill != w_eff);
    assign advance     = !r_out_v || !i_stall;
    assign accept      = i_valid && advance;
    assign cfg_wr      = i_cfg_valid;
    assign o_stall     = !advance;
    assign o_cfg_ready = 1'b1;
    assign wr_addr     = filling ? r_fill[IDX_W-1:0] : r_ptr;

    always_comb begin
        n_fill  = r_fill;
        n_ptr   = r_ptr;
        produce = 1'b0;
        if (cfg_wr) begin
            n_fill = '0;
            n_ptr  = '0;
        end else if (accept) begin
            if (filling) begin
                n_fill  = r_fill + CNT_W'(1);
                n_ptr   = '0;
                produce = (n_fill == w_eff);
            end else begin
                produce = 1'b1;
                if (CNT_W'(r_ptr) == w_eff - CNT_W'(1)) begin
                    n_ptr = '0;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= swm_pkg::CFG_RESET;
            r_fill <= '0;
            r_ptr  <= '0;
        end else begin
            if (cfg_wr) begin
                r_win <= i_window_size;
            end
            r_fill <= n_fill;
            r_ptr  <= n_ptr;
        end
    end

    // ring of arrival order; read address runs ahead of the write address so the
    // departing sample is ready when the next beat arrives
    swm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (accept && !cfg_wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample_value),
        .i_rd_addr (n_ptr),
        .o_rd_data (old_raw)
    );

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            logic signed [SAMPLE_WIDTH-1:0] below_value;
            swm_pkg::t_cell_flags           below_flags;
            logic signed [SAMPLE_WIDTH-1:0] above_value;
            swm_pkg::t_cell_flags           above_flags;

            if (gi == 0) begin : g_lo
                assign below_value    = '0;
                assign below_flags.le = 1'b1;
                assign below_flags.lt = 1'b1;
            end else begin : g_mid_lo
                assign below_value = cell_val[gi-1];
                assign below_flags = cell_flg[gi-1];
            end

            if (gi == MAX_WINDOW - 1) begin : g_hi
                assign above_value    = '0;
                assign above_flags.le = 1'b0;
                assign above_flags.lt = 1'b0;
            end else begin : g_mid_hi
                assign above_value = cell_val[gi+1];
                assign above_flags = cell_flg[gi+1];
            end

            assign cell_ctl[gi].valid   = (CNT_W'(gi) < r_fill);
            assign cell_ctl[gi].keep    = filling ? (CNT_W'(gi) < r_fill)
                                                  : (CNT_W'(gi) < w_eff - CNT_W'(1));
            assign cell_ctl[gi].use_old = !filling;

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_load        (accept && !cfg_wr),
                .i_new         (i_sample_value),
                .i_old         ($signed(old_raw)),
                .i_ctl         (cell_ctl[gi]),
                .i_below_value (below_value),
                .i_below_flags (below_flags),
                .i_above_value (above_value),
                .i_above_flags (above_flags),
                .o_value       (cell_val[gi]),
                .o_flags       (cell_flg[gi])
            );
        end

        for (gi = 0; gi < PAD; gi++) begin : g_sel
            if (gi < MAX_WINDOW) begin : g_leaf
                assign sel_val[gi] = (IDX_W'(gi) == mid) ? cell_val[gi] : '0;
            end else begin : g_fill
                assign sel_val[gi] = '0;
            end
        end
    endgenerate

    // median select: one-hot and-or over the row, two registered levels
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                n_grp[g] = n_grp[g] | sel_val[g*GROUP + j];
            end
        end
        n_out = '0;
        for (int g = 0; g < NGROUP; g++) begin
            n_out = n_out | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_grp_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_pend  <= accept && produce;
            r_grp_v <= r_pend;
            r_out_v <= r_grp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_grp <= n_grp;
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_v;
    assign o_median_value = $signed(r_out);

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fill <= w_eff)
        else $error("fill count beyond window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !filling |-> (CNT_W'(r_ptr) < w_eff))
        else $error("ring pointer outside window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_grp_v))
        else $error("result without select stage");

    generate
        if (MAX_WINDOW > 1) begin : g_chk_order
            assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_fill >= CNT_W'(2)) |-> (cell_val[0] <= cell_val[1]))
                else $error("sorted row out of order");
        end
    endgenerate

endmodule

/* sv/swm_ram.sv */
module swm_ram #(
    parameter int WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int DEPTH = swm_pkg::MAX_WINDOW_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the contents before a write to the same address
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/swm_cell.sv */
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic signed [SAMPLE_WIDTH-1:0] i_new,
    input  logic signed [SAMPLE_WIDTH-1:0] i_old,
    input  swm_pkg::t_cell_ctl             i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_below_value,
    input  swm_pkg::t_cell_flags           i_below_flags,
    input  logic signed [SAMPLE_WIDTH-1:0] i_above_value,
    input  swm_pkg::t_cell_flags           i_above_flags,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output swm_pkg::t_cell_flags           o_flags
);

    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic signed [SAMPLE_WIDTH-1:0] n_value;
    logic                           le;
    logic                           lt;
    logic                           self_le;
    logic                           below_le;
    logic signed [SAMPLE_WIDTH-1:0] self_val;
    logic signed [SAMPLE_WIDTH-1:0] below_val;

    // self_* / below_* describe the window with the departing sample taken out,
    // at this slot and at the slot below
    always_comb begin
        le        = i_ctl.valid && !(i_new < r_value);
        lt        = i_ctl.keep && (!i_ctl.use_old || (r_value < i_old));
        self_le   = lt ? le : i_above_flags.le;
        self_val  = lt ? r_value : i_above_value;
        below_le  = i_below_flags.lt ? i_below_flags.le : le;
        below_val = i_below_flags.lt ? i_below_value : r_value;
        if (self_le) begin
            n_value = self_val;
        end else if (below_le) begin
            n_value = i_new;
        end else begin
            n_value = below_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= n_value;
        end
    end

    assign o_value    = r_value;
    assign o_flags.le = le;
    assign o_flags.lt = lt;

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW            = swm_pkg::SAMPLE_WIDTH_DEF;
    localparam int MAXW          = swm_pkg::MAX_WINDOW_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int SEG_ITEMS     = 64;
    localparam int NUM_SEGS      = 12;

    typedef logic signed [SW-1:0]            t_sample;
    typedef logic [swm_pkg::CFG_WIDTH-1:0]   t_wsize;

    localparam t_sample S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam t_sample S_MAX = {1'b0, {(SW-1){1'b1}}};

    logic    i_clk          = 1'b0;
    logic    i_rst_n        = 1'b0;
    logic    i_valid        = 1'b0;
    t_sample i_sample_value = '0;
    logic    i_stall        = 1'b0;
    logic    i_cfg_valid    = 1'b0;
    t_wsize  i_window_size  = swm_pkg::CFG_RESET;
    logic    o_stall;
    logic    o_valid;
    t_sample o_median_value;
    logic    o_cfg_ready;

    sliding_window_median_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_median_value (o_median_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_window_size  (i_window_size)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_sample samples_to_send[$];
    t_sample window_arrivals[$];
    t_sample window_sorted[$];
    t_sample medians_due[$];
    t_sample due_median;
    int      window_len;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      errors = 0;

    function automatic int effective_len(t_wsize v);
        if (v == 0) return 1;
        if (v > MAXW) return MAXW;
        return int'(v);
    endfunction

    // slide the window by one sample and queue the lower median once it is full
    task automatic advance_window(t_sample s);
        t_sample oldest;
        int      k;
        if (window_arrivals.size() == window_len) begin
            oldest = window_arrivals.pop_front();
            for (k = 0; k < window_sorted.size(); k++) begin
                if (window_sorted[k] == oldest) begin
                    window_sorted.delete(k);
                    break;
                end
            end
        end
        window_arrivals.push_back(s);
        k = 0;
        while (k < window_sorted.size() && !(s < window_sorted[k])) k++;
        window_sorted.insert(k, s);
        if (window_arrivals.size() == window_len)
            medians_due.push_back(window_sorted[(window_len - 1) / 2]);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? S_MIN : S_MAX;
            1, 2, 3: return t_sample'(int'($urandom_range(0, 8)) - 4);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                advance_window(i_sample_value);
            if (!i_valid || !o_stall) begin
                if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid        <= 1'b1;
                    i_sample_value <= samples_to_send.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (medians_due.size() == 0) begin
                $error("median_value: expected none, got %0d", o_median_value);
                errors++;
            end else begin
                due_median = medians_due.pop_front();
                if (o_median_value !== due_median) begin
                    $error("median_value: expected %0d, got %0d", due_median, o_median_value);
                    errors++;
                end
            end
        end
    end

    // wait until every sample went in and every median came out
    task automatic drain();
        do @(negedge i_clk);
        while (samples_to_send.size() != 0 || i_valid || medians_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window(t_wsize v);
        @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_window_size <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_arrivals.delete();
        window_sorted.delete();
        window_len = effective_len(v);
    endtask

    initial begin
        t_wsize seg_size [NUM_SEGS];
        int     seg, n;
        seg_size = '{7'd2, 7'd64, 7'd5, 7'd127, 7'd1, 7'd0, 7'd8, 7'd65, 7'd0, 7'd0, 7'd0, 7'd0};
        for (seg = 8; seg < NUM_SEGS; seg++) seg_size[seg] = t_wsize'($urandom_range(0, 127));

        window_len    = effective_len(swm_pkg::CFG_RESET);
        send_idle_pct = 9;
        recv_idle_pct = 70;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window of three: extremes and repeated values
        samples_to_send = '{S_MIN, S_MAX, 0, -1, 1, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, 0, 0};
        drain();
        // zero acts as a window of one
        write_window(7'd0);
        samples_to_send = '{S_MAX, S_MIN, -1, 1};
        drain();

        for (seg = 0; seg < NUM_SEGS; seg++) begin
            if (seg < 4) begin
                send_idle_pct = 9;
                recv_idle_pct = 70;
            end else if (seg < 8) begin
                send_idle_pct = 70;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_window(seg_size[seg]);
            for (n = 0; n < SEG_ITEMS; n++) samples_to_send.push_back(rand_sample());
            // sender holds off mid-stream until all medians are back
            drain();
            for (n = 0; n < SEG_ITEMS; n++) samples_to_send.push_back(rand_sample());
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
